FILE: rtl/core/evpd_pkg.sv
// shared types, register codes and constants for the encoder velocity pd pwm block
// no dependencies; imported by every module of the block
package evpd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned NUM_W   = 55;
  localparam int unsigned DEN_W   = 36;
  localparam int unsigned CTL_W   = 50;
  localparam int unsigned VEL_Q_W = 32;
  localparam int unsigned MV_W    = 31;
  localparam int unsigned CMP_W   = 16;

  localparam logic [NUM_W-1:0] VEL_SCALE_K = 55'd411774832291;
  localparam logic signed [31:0] BRAKE_VEL = 32'sd6553;

  localparam logic [15:0]     GAIN_P_RST  = 16'd25600;
  localparam logic [15:0]     GAIN_D_RST  = 16'd2048;
  localparam logic [15:0]     CPR_RST     = 16'd1560;
  localparam logic [15:0]     PWM_TOP_RST = 16'd1000;
  localparam logic [MV_W-1:0] MAX_VEL_RST = 31'd2470368;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_D  = 3'd1,
    REG_CPR     = 3'd2,
    REG_PWM_TOP = 3'd3,
    REG_MAX_VEL = 3'd4,
    REG_MOT_REV = 3'd5,
    REG_ENC_REV = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] encoder_delta;
    logic [19:0]        interval_us;
    logic signed [31:0] vel_setpoint;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        compare_value;
    logic               drive_forward;
    logic               braking;
    logic signed [31:0] position_count;
    logic signed [31:0] measured_velocity;
  } out_item_t;

endpackage

FILE: rtl/core/encoder_velocity_pd_pwm_top.sv
// encoder velocity pd controller with pwm compare output: sequencer, state and registers
// depends on evpd_pkg, evpd_ser_mul and evpd_ser_div
//
// usage
//   input channel in_valid / in_stall / in_data carries one control tick per item:
//   encoder delta, interval in microseconds and target velocity (q16.16 rad/s).
//   result channel out_valid / out_stall / out_data returns one item per tick:
//   pwm compare, direction pin, brake flag, position count and measured velocity.
//   cfg_valid / cfg_ready / cfg_index / cfg_data writes the seven registers; cfg_ready
//   is always high. the user must make writes while no item is in flight; unenforced.
// sequencing
//   one item at a time. the serial units run in sequence up to the result register,
//   each pair of multipliers together; the velocity division is skipped when its
//   quotient overflows. they are shift-add multipliers with 16-bit multiplier
//   operands and restoring dividers of 32 and 16 quotient bits.
//   in_stall is high from acceptance until the result is moved to the output register.
// reset and stall
//   synchronous active-low reset clears position, last error and direction and
//   loads register defaults. a stalled result stays in the output register; the
//   next item may be accepted meanwhile but its result waits until that one is taken.
module encoder_velocity_pd_pwm_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  evpd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output evpd_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [evpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import evpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_DIVV, S_VEL, S_ERR, S_DIFF,
    S_PD, S_ABS, S_CMP, S_CMUL, S_CDIV, S_OUT
  } state_t;

  // configuration registers
  logic [15:0]     gp_r, gd_r, cpr_r, pwm_top_r;
  logic [MV_W-1:0] max_vel_r;
  logic            mrev_r, erev_r;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   dir_r, dir_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic signed [31:0] last_err_r, last_err_nxt;

  logic               d_neg_r, d_neg_nxt;
  logic signed [31:0] target_r, target_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic               qbig_r, qbig_nxt;
  logic signed [31:0] vel_r, vel_nxt, err_r, err_nxt;
  logic [CTL_W-1:0]   ctl_r, ctl_nxt;
  logic [CTL_W-2:0]   cm_r, cm_nxt;
  logic               ctl_neg_r, ctl_neg_nxt, ctl_nz_r, ctl_nz_nxt;
  logic               brake_r, brake_nxt, sat_r, sat_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               in_acc;
  logic signed [16:0] d17, d_eff, d_abs;
  logic [19:0]        iv_eff;
  logic [15:0]        cpr_eff;
  logic [MV_W-1:0]    mv_eff;
  logic [32:0]        q33, e33, diff33;
  logic [CTL_W-1:0]   ctl_neg_val;
  logic [MV_W+7:0]    limit;
  logic               tpos, tneg;

  logic               mul_start, pd_start, cm_start, divv_start, divc_start;
  logic [NUM_W-1:0]   num_prod, c_prod, c_a;
  logic [DEN_W-1:0]   den_prod, den_a, divv_rem;
  logic [CTL_W-1:0]   p_prod, d_prod, p_a, d_a;
  logic [VEL_Q_W-1:0] divv_q;
  logic [CMP_W-1:0]   divc_q;
  logic               num_done, den_done, p_done, d_done, divv_done, divc_done;
  logic               c_done_w;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign d17     = {in_data.encoder_delta[15], in_data.encoder_delta};
  assign d_eff   = erev_r ? (17'sd0 - d17) : d17;
  assign d_abs   = d_eff[16] ? (17'sd0 - d_eff) : d_eff;
  assign iv_eff  = (in_data.interval_us == '0) ? 20'd1 : in_data.interval_us;
  assign cpr_eff = (cpr_r == '0) ? 16'd1 : cpr_r;
  assign mv_eff  = (max_vel_r == '0) ? MV_W'(1) : max_vel_r;
  assign den_a   = {16'd0, iv_eff};
  assign limit   = {mv_eff, 8'd0};

  assign q33    = qbig_r ? 33'h1_FFFF_FFFF : {1'b0, divv_q};
  assign e33    = {target_r[31], target_r} - {vel_r[31], vel_r};
  assign diff33 = {err_r[31], err_r} - {last_err_r[31], last_err_r};
  assign p_a    = {{(CTL_W-32){err_r[31]}}, err_r};
  assign d_a    = {{(CTL_W-33){diff33[32]}}, diff33};
  assign ctl_neg_val = '0 - ctl_r;
  assign c_a    = {{(NUM_W-MV_W-8){1'b0}}, cm_r[MV_W+7:0]};
  assign divv_rem = {{(DEN_W-(NUM_W-VEL_Q_W)){1'b0}}, num_r[NUM_W-1:VEL_Q_W]};
  assign tpos   = !target_r[31] && (target_r != '0);
  assign tneg   = target_r[31];

  assign mul_start  = in_acc;
  assign divv_start = (state_r == S_PREP) && !(divv_rem >= den_r);
  assign pd_start   = (state_r == S_DIFF);
  assign cm_start   = (state_r == S_CMP);
  assign divc_start = (state_r == S_CMUL) && c_done_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r      <= GAIN_P_RST;
      gd_r      <= GAIN_D_RST;
      cpr_r     <= CPR_RST;
      pwm_top_r <= PWM_TOP_RST;
      max_vel_r <= MAX_VEL_RST;
      mrev_r    <= 1'b0;
      erev_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:  gp_r      <= cfg_data[15:0];
        REG_GAIN_D:  gd_r      <= cfg_data[15:0];
        REG_CPR:     cpr_r     <= cfg_data[15:0];
        REG_PWM_TOP: pwm_top_r <= cfg_data[15:0];
        REG_MAX_VEL: max_vel_r <= cfg_data[MV_W-1:0];
        REG_MOT_REV: mrev_r    <= cfg_data[0];
        REG_ENC_REV: erev_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    dir_nxt       = dir_r;
    pos_nxt       = pos_r;
    last_err_nxt  = last_err_r;
    d_neg_nxt     = d_neg_r;
    target_nxt    = target_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    qbig_nxt      = qbig_r;
    vel_nxt       = vel_r;
    err_nxt       = err_r;
    ctl_nxt       = ctl_r;
    cm_nxt        = cm_r;
    ctl_neg_nxt   = ctl_neg_r;
    ctl_nz_nxt    = ctl_nz_r;
    brake_nxt     = brake_r;
    sat_nxt       = sat_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          d_neg_nxt  = d_eff[16];
          target_nxt = in_data.vel_setpoint;
          pos_nxt    = pos_r + {{15{d_eff[16]}}, d_eff};
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        if (num_done) begin
          num_nxt   = num_prod + {{(NUM_W-DEN_W+1){1'b0}}, den_prod[DEN_W-1:1]};
          den_nxt   = den_prod;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        qbig_nxt  = divv_rem >= den_r;
        state_nxt = (divv_rem >= den_r) ? S_VEL : S_DIVV;
      end
      S_DIVV: begin
        if (divv_done) begin
          state_nxt = S_VEL;
        end
      end
      S_VEL: begin
        if (d_neg_r) begin
          vel_nxt = (q33 > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(33'd0 - q33);
        end else begin
          vel_nxt = (q33 > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : q33[31:0];
        end
        state_nxt = S_ERR;
      end
      S_ERR: begin
        if (e33[32] != e33[31]) begin
          err_nxt = e33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          err_nxt = e33[31:0];
        end
        brake_nxt = (tpos && (vel_r < -BRAKE_VEL)) || (tneg && (vel_r > BRAKE_VEL));
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        last_err_nxt = err_r;
        state_nxt    = S_PD;
      end
      S_PD: begin
        if (p_done) begin
          ctl_nxt   = p_prod + d_prod;
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        cm_nxt      = ctl_r[CTL_W-1] ? ctl_neg_val[CTL_W-2:0] : ctl_r[CTL_W-2:0];
        ctl_neg_nxt = ctl_r[CTL_W-1];
        ctl_nz_nxt  = (ctl_r != '0);
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        sat_nxt   = cm_r >= {{(CTL_W-1-MV_W-8){1'b0}}, limit};
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        if (c_done_w) begin
          state_nxt = S_CDIV;
        end
      end
      S_CDIV: begin
        if (divc_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          if (!brake_r) begin
            if (ctl_neg_r) begin
              dir_nxt = mrev_r;
            end else if (ctl_nz_r) begin
              dir_nxt = !mrev_r;
            end
          end
          out_data_nxt.compare_value     = brake_r ? 16'd0 : (sat_r ? pwm_top_r : divc_q);
          out_data_nxt.drive_forward     = dir_nxt;
          out_data_nxt.braking           = brake_r;
          out_data_nxt.position_count    = pos_r;
          out_data_nxt.measured_velocity = vel_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dir_r       <= 1'b0;
      pos_r       <= '0;
      last_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dir_r       <= dir_nxt;
      pos_r       <= pos_nxt;
      last_err_r  <= last_err_nxt;
    end
    d_neg_r    <= d_neg_nxt;
    target_r   <= target_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    qbig_r     <= qbig_nxt;
    vel_r      <= vel_nxt;
    err_r      <= err_nxt;
    ctl_r      <= ctl_nxt;
    cm_r       <= cm_nxt;
    ctl_neg_r  <= ctl_neg_nxt;
    ctl_nz_r   <= ctl_nz_nxt;
    brake_r    <= brake_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

  // |delta| * scale and counts_per_rev * interval
  evpd_ser_mul #(.PW(NUM_W), .BW(MUL_B_W)) u_mul_num (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(VEL_SCALE_K),
    .b(d_abs[15:0]), .prod(num_prod), .done(num_done)
  );

  evpd_ser_mul #(.PW(DEN_W), .BW(MUL_B_W)) u_mul_den (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(den_a),
    .b(cpr_eff), .prod(den_prod), .done(den_done)
  );

  evpd_ser_div #(.DW(DEN_W), .QW(VEL_Q_W)) u_div_vel (
    .clk(clk), .rst_n(rst_n), .start(divv_start), .rem_init(divv_rem),
    .num_lo(num_r[VEL_Q_W-1:0]), .divisor(den_r), .quot(divv_q), .done(divv_done)
  );

  // pd terms
  evpd_ser_mul #(.PW(CTL_W), .BW(MUL_B_W)) u_mul_p (
    .clk(clk), .rst_n(rst_n), .start(pd_start), .a(p_a),
    .b(gp_r), .prod(p_prod), .done(p_done)
  );

  evpd_ser_mul #(.PW(CTL_W), .BW(MUL_B_W)) u_mul_d (
    .clk(clk), .rst_n(rst_n), .start(pd_start), .a(d_a),
    .b(gd_r), .prod(d_prod), .done(d_done)
  );

  // |control| * pwm_top / (max velocity * 256)
  evpd_ser_mul #(.PW(NUM_W), .BW(MUL_B_W)) u_mul_cmp (
    .clk(clk), .rst_n(rst_n), .start(cm_start), .a(c_a),
    .b(pwm_top_r), .prod(c_prod), .done(c_done_w)
  );

  evpd_ser_div #(.DW(MV_W), .QW(CMP_W)) u_div_cmp (
    .clk(clk), .rst_n(rst_n), .start(divc_start), .rem_init(c_prod[NUM_W-1:NUM_W-MV_W]),
    .num_lo(c_prod[CMP_W+7:8]), .divisor(mv_eff), .quot(divc_q), .done(divc_done)
  );

  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in flight");

  a_mul_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (num_done == den_done) && (p_done == d_done))
    else $error("paired serial multipliers out of step");

  a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.braking) |-> (out_data.compare_value == 16'd0))
    else $error("non-zero compare while braking");

  a_cmp_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.compare_value <= pwm_top_r))
    else $error("compare above pwm top");

endmodule

FILE: rtl/core/evpd_ser_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on evpd_pkg for default widths
module evpd_ser_mul #(
  parameter int unsigned PW = evpd_pkg::NUM_W,
  parameter int unsigned BW = evpd_pkg::MUL_B_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [PW-1:0] prod,
  output logic          done
);
  import evpd_pkg::*;

  localparam int unsigned CW = $clog2(BW + 1);

  logic [PW-1:0] a_r, a_nxt, acc_r, acc_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = CW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (b_r[0] ? a_r : '0);
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

FILE: rtl/core/evpd_ser_div.sv
// restoring divider, one quotient bit per cycle
// depends on evpd_pkg for default widths
module evpd_ser_div #(
  parameter int unsigned DW = evpd_pkg::DEN_W,
  parameter int unsigned QW = evpd_pkg::VEL_Q_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quot,
  output logic          done
);
  import evpd_pkg::*;

  localparam int unsigned CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt, d_r, d_nxt;
  logic [QW-1:0] n_r, n_nxt, q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial, trial_sub;
  logic          ge;

  assign trial     = {rem_r, n_r[QW-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign ge        = trial >= {1'b0, d_r};

  always_comb begin
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      d_nxt    = divisor;
      n_nxt    = num_lo;
      q_nxt    = '0;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      q_nxt   = {q_r[QW-2:0], ge};
      n_nxt   = n_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

endmodule
